// ----- rtl/bhu_pkg.sv -----
// Shared types and constants for the bisector hyperplane unit.
// No dependencies; compile first.
package bhu_pkg;

  localparam logic signed [31:0] Q30_ONE = 32'sh4000_0000;
  localparam int unsigned NORM_LOW_BIT  = 27;  // scaled span lies in [2^27, 2^28)
  localparam int unsigned NORM_HIGH_BIT = 28;
  localparam int unsigned DIV_STEPS     = 31;  // quotient bits, at most 2^30
  localparam logic [63:0] ROOT_FIRST_BIT = 64'h4000_0000_0000_0000;

  typedef struct packed {
    logic signed [31:0] left_coord;
    logic signed [31:0] right_coord;
    logic               mode;
    logic [5:0]         axis;
    logic               last_coord;
  } pair_t;

  typedef struct packed {
    logic signed [31:0] normal_comp;
    logic [5:0]         comp_index;
    logic signed [31:0] plane_offset;
    logic               points_swapped;
    logic               degenerate;
    logic               last_result;
  } result_t;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_SPAN,
    ST_NORM,
    ST_SCALE,
    ST_SQUARE,
    ST_SUM,
    ST_ROOT,
    ST_DIV_INIT,
    ST_DIV,
    ST_DIV_STORE,
    ST_DOT,
    ST_DOT_SUM,
    ST_ROUND,
    ST_EMIT
  } state_t;

endpackage

// ----- rtl/bhu_stream_if.sv -----
// Valid/ready stream channel carrying one word of payload type T.
// Depends on nothing; the payload types come from bhu_pkg at instantiation.
interface bhu_stream_if #(parameter type T = logic);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- rtl/bisector_hyperplane_unit.sv -----
// Top level of the bisector hyperplane unit: loads two points, computes the
// unit normal and offset of the cutting hyperplane, streams them out.
// Depends on bhu_pkg and bhu_stream_if.
//
//  channel | dir | payload         | word
//  --------+-----+-----------------+-------------------------------------
//  coords  | in  | bhu_pkg::pair_t | one coordinate pair, last_coord ends
//  planes  | out | bhu_pkg::result_t | one normal component plus offset
//
// After the closing word with n pairs the bisector pass runs in order: span,
// normalize, squares, bit-serial root, bit-serial divide, dot product and
// rounding, then emits one result per element; axis mode skips straight to
// the dot product, and an all-zero span skips to emitting. The serial root
// and divider work one bit per cycle.
// rst is synchronous; it returns the unit to loading with an empty vector.
// A stalled planes word holds; coords is taken only while loading.
module bisector_hyperplane_unit #(
  parameter int DIM = 8
) (
  input  logic       clk,
  input  logic       rst,
  bhu_stream_if.sink   coords,
  bhu_stream_if.source planes
);

  localparam int IW = (DIM > 1) ? $clog2(DIM) : 1;
  localparam int CW = $clog2(DIM + 1);

  bhu_pkg::state_t state, state_next;

  // point stores, written while loading, walked by idx afterwards
  logic [31:0] left_store  [DIM];
  logic [31:0] right_store [DIM];
  logic signed [31:0] comp_store [DIM];

  logic [CW-1:0] load_count, n_count;
  logic [IW-1:0] idx;
  logic          latched_mode;
  logic [5:0]    latched_axis;
  logic          swapped, degenerate;

  logic [32:0]   max_mag, norm_mag;
  logic [2:0]    down;
  logic [4:0]    up;
  logic [27:0]   smag;
  logic [55:0]   square;
  logic [63:0]   sum_squares;
  logic [63:0]   root_v, root_res, root_bit;
  logic [31:0]   norm;
  logic [31:0]   rem;
  logic [30:0]   dvd;
  logic [4:0]    step;
  logic          div_neg;
  logic signed [64:0] dot_prod;
  logic signed [71:0] mid_dot_diff;
  logic signed [31:0] offset;

  logic          out_valid;
  bhu_pkg::result_t out_word;

  // per-element datapath
  logic [31:0]        lsel, rsel;
  logic signed [32:0] diff, pair_sum;
  logic               dneg;
  logic [32:0]        dmag, max_next;
  logic [27:0]        scaled;
  logic [58:0]        numer;
  logic [32:0]        trial;
  logic               qbit;
  logic signed [31:0] comp_val;
  logic signed [71:0] rnd, shifted;
  logic               elem_last, in_fire, emit_go, mode_eff;
  logic [CW-1:0]      count_next;

  always_comb begin
    lsel     = left_store[idx];
    rsel     = right_store[idx];
    diff     = $signed({rsel[31], rsel}) - $signed({lsel[31], lsel});
    pair_sum = $signed({lsel[31], lsel}) + $signed({rsel[31], rsel});
    dneg     = diff[32];
    dmag     = dneg ? 33'(-diff) : 33'(diff);
    max_next = (dmag > max_mag) ? dmag : max_mag;
    scaled   = 28'((dmag >> down) << up);
    numer    = {1'b0, scaled, 30'b0} + 59'(norm >> 1);
    trial    = {rem, dvd[30]};
    qbit     = (trial >= {1'b0, norm});
    if (latched_mode) begin
      comp_val = (6'(idx) == latched_axis) ? bhu_pkg::Q30_ONE : 32'sd0;
    end else if (degenerate) begin
      comp_val = 32'sd0;
    end else begin
      comp_val = swapped ? -comp_store[idx] : comp_store[idx];
    end
    // round half up of the exact sum over 2^31
    rnd     = mid_dot_diff + 72'sh4000_0000;
    shifted = rnd >>> 31;
    elem_last  = ((CW'(idx) + CW'(1)) == n_count);
    count_next = (load_count < CW'(DIM)) ? load_count + CW'(1) : load_count;
    mode_eff   = (load_count == '0) ? coords.data.mode : latched_mode;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      bhu_pkg::ST_LOAD:
        if (in_fire && coords.data.last_coord) begin
          state_next = mode_eff ? bhu_pkg::ST_DOT : bhu_pkg::ST_SPAN;
        end
      bhu_pkg::ST_SPAN:
        if (elem_last) begin
          state_next = (max_next == '0) ? bhu_pkg::ST_EMIT : bhu_pkg::ST_NORM;
        end
      bhu_pkg::ST_NORM:
        if (norm_mag < (33'd1 << bhu_pkg::NORM_HIGH_BIT) &&
            norm_mag >= (33'd1 << bhu_pkg::NORM_LOW_BIT)) begin
          state_next = bhu_pkg::ST_SCALE;
        end
      bhu_pkg::ST_SCALE:  state_next = bhu_pkg::ST_SQUARE;
      bhu_pkg::ST_SQUARE: state_next = bhu_pkg::ST_SUM;
      bhu_pkg::ST_SUM:
        state_next = elem_last ? bhu_pkg::ST_ROOT : bhu_pkg::ST_SCALE;
      bhu_pkg::ST_ROOT:
        if (root_bit == '0) begin
          state_next = bhu_pkg::ST_DIV_INIT;
        end
      bhu_pkg::ST_DIV_INIT: state_next = bhu_pkg::ST_DIV;
      bhu_pkg::ST_DIV:
        if (step == '0) begin
          state_next = bhu_pkg::ST_DIV_STORE;
        end
      bhu_pkg::ST_DIV_STORE:
        state_next = elem_last ? bhu_pkg::ST_DOT : bhu_pkg::ST_DIV_INIT;
      bhu_pkg::ST_DOT:     state_next = bhu_pkg::ST_DOT_SUM;
      bhu_pkg::ST_DOT_SUM:
        state_next = elem_last ? bhu_pkg::ST_ROUND : bhu_pkg::ST_DOT;
      bhu_pkg::ST_ROUND:   state_next = bhu_pkg::ST_EMIT;
      bhu_pkg::ST_EMIT:
        if (emit_go && elem_last) begin
          state_next = bhu_pkg::ST_LOAD;
        end
      default: state_next = bhu_pkg::ST_LOAD;
    endcase
  end

  // handshake outputs
  always_comb begin
    coords.ready = (state == bhu_pkg::ST_LOAD);
    in_fire      = coords.valid && coords.ready;
    emit_go      = (state == bhu_pkg::ST_EMIT) && (!out_valid || planes.ready);
    planes.valid = out_valid;
    planes.data  = out_word;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= bhu_pkg::ST_LOAD;
    end else begin
      state <= state_next;
    end
  end

  // control counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      load_count   <= '0;
      n_count      <= '0;
      idx          <= '0;
      latched_mode <= 1'b0;
      latched_axis <= '0;
      swapped      <= 1'b0;
      degenerate   <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      // drop the held word once taken, unless a new one replaces it
      if (planes.valid && planes.ready && !emit_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        bhu_pkg::ST_LOAD:
          if (in_fire) begin
            if (load_count == '0) begin
              latched_mode <= coords.data.mode;
              latched_axis <= coords.data.axis;
            end
            load_count <= coords.data.last_coord ? '0 : count_next;
            if (coords.data.last_coord) begin
              n_count    <= count_next;
              idx        <= '0;
              swapped    <= 1'b0;
              degenerate <= 1'b0;
            end
          end
        bhu_pkg::ST_SPAN: begin
          idx <= elem_last ? '0 : idx + IW'(1);
          if (elem_last && max_next == '0) begin
            degenerate <= 1'b1;
          end
        end
        bhu_pkg::ST_SUM:
          idx <= elem_last ? '0 : idx + IW'(1);
        bhu_pkg::ST_DIV_STORE: begin
          idx <= elem_last ? '0 : idx + IW'(1);
          if (idx == '0 && div_neg && dvd != '0) begin
            swapped <= 1'b1;
          end
        end
        bhu_pkg::ST_DOT_SUM:
          idx <= elem_last ? '0 : idx + IW'(1);
        bhu_pkg::ST_EMIT:
          if (emit_go) begin
            out_valid <= 1'b1;
            idx <= elem_last ? '0 : idx + IW'(1);
          end
        default: ;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      bhu_pkg::ST_LOAD: begin
        if (in_fire && load_count < CW'(DIM)) begin
          left_store[load_count[IW-1:0]]  <= coords.data.left_coord;
          right_store[load_count[IW-1:0]] <= coords.data.right_coord;
        end
        max_mag      <= '0;
        mid_dot_diff <= '0;
        offset       <= '0;
        sum_squares  <= '0;
      end
      bhu_pkg::ST_SPAN: begin
        max_mag  <= max_next;
        norm_mag <= max_next;
        down     <= '0;
        up       <= '0;
      end
      bhu_pkg::ST_NORM:
        // walk the span one bit a step into [2^27, 2^28)
        if (norm_mag >= (33'd1 << bhu_pkg::NORM_HIGH_BIT)) begin
          norm_mag <= norm_mag >> 1;
          down     <= down + 3'd1;
        end else if (norm_mag < (33'd1 << bhu_pkg::NORM_LOW_BIT)) begin
          norm_mag <= norm_mag << 1;
          up       <= up + 5'd1;
        end
      bhu_pkg::ST_SCALE:  smag   <= scaled;
      bhu_pkg::ST_SQUARE: square <= smag * smag;
      bhu_pkg::ST_SUM: begin
        sum_squares <= sum_squares + 64'(square);
        root_v      <= sum_squares + 64'(square);
        root_res    <= '0;
        root_bit    <= bhu_pkg::ROOT_FIRST_BIT;
      end
      bhu_pkg::ST_ROOT: begin
        if (root_bit != '0) begin
          if (root_v >= root_res + root_bit) begin
            root_v   <= root_v - (root_res + root_bit);
            root_res <= (root_res >> 1) + root_bit;
          end else begin
            root_res <= root_res >> 1;
          end
          root_bit <= root_bit >> 2;
        end
        norm <= root_res[31:0];
      end
      bhu_pkg::ST_DIV_INIT: begin
        rem     <= 32'(numer[58:31]);
        dvd     <= numer[30:0];
        step    <= 5'(bhu_pkg::DIV_STEPS - 1);
        div_neg <= dneg;
      end
      bhu_pkg::ST_DIV: begin
        rem  <= qbit ? 32'(trial - {1'b0, norm}) : trial[31:0];
        dvd  <= {dvd[29:0], qbit};
        step <= step - 5'd1;
      end
      bhu_pkg::ST_DIV_STORE:
        comp_store[idx] <= div_neg ? -$signed({1'b0, dvd}) : $signed({1'b0, dvd});
      bhu_pkg::ST_DOT:     dot_prod <= pair_sum * comp_val;
      bhu_pkg::ST_DOT_SUM: mid_dot_diff <= mid_dot_diff + 72'(dot_prod);
      bhu_pkg::ST_ROUND:
        if (shifted > 72'sd2147483647) begin
          offset <= 32'sh7fff_ffff;
        end else if (shifted < -72'sd2147483648) begin
          offset <= 32'sh8000_0000;
        end else begin
          offset <= shifted[31:0];
        end
      bhu_pkg::ST_EMIT:
        if (emit_go) begin
          out_word.normal_comp    <= comp_val;
          out_word.comp_index     <= 6'(idx);
          out_word.plane_offset   <= offset;
          out_word.points_swapped <= swapped;
          out_word.degenerate     <= degenerate;
          out_word.last_result    <= elem_last;
        end
      default: ;
    endcase
  end

  // the fill count never runs past the store depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    load_count <= CW'(DIM)) else $error("load count beyond DIM");

  // a finished quotient is a unit-range magnitude
  a_quot_range: assert property (@(posedge clk) disable iff (rst)
    state == bhu_pkg::ST_DIV_STORE |-> dvd <= 31'(bhu_pkg::Q30_ONE))
    else $error("quotient above one");

  // coincident points never report a swap
  a_degen_swap: assert property (@(posedge clk) disable iff (rst)
    degenerate |-> !swapped) else $error("swap flagged on degenerate run");

  // results are only produced while emitting
  a_emit_only: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == bhu_pkg::ST_EMIT)
    else $error("result word outside emit");

endmodule
